>>> design/md5_pkg.sv
// md5 engine package: types, state encoding, round constants and tables
// no dependencies
package md5_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } md5_state_t;

  // byte source for buffer writes
  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_t;

  typedef struct packed {
    logic      wr_byte;
    byte_src_t src;
    logic      count_up;
    logic      start_rounds;
    logic      round_step;
    logic      fold;
    logic      reinit;
    logic      save_len;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic [5:0] round;
    logic       in_tail;
  } md5_status_t;

  function automatic logic [31:0] round_const(input logic [5:0] k);
    logic [31:0] t [64];
    t = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    return t[k];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] k);
    logic [4:0] r;
    case ({k[5:4], k[1:0]})
      4'b0000: r = 5'd7;
      4'b0001: r = 5'd12;
      4'b0010: r = 5'd17;
      4'b0011: r = 5'd22;
      4'b0100: r = 5'd5;
      4'b0101: r = 5'd9;
      4'b0110: r = 5'd14;
      4'b0111: r = 5'd20;
      4'b1000: r = 5'd4;
      4'b1001: r = 5'd11;
      4'b1010: r = 5'd16;
      4'b1011: r = 5'd23;
      4'b1100: r = 5'd6;
      4'b1101: r = 5'd10;
      4'b1110: r = 5'd15;
      4'b1111: r = 5'd21;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // message word index per round
  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] g;
    case (k[5:4])
      2'd0: g = k[3:0];
      2'd1: g = 4'(({2'b0, k} * 8'd5) + 8'd1);
      2'd2: g = 4'(({2'b0, k} * 8'd3) + 8'd5);
      2'd3: g = 4'({2'b0, k} * 8'd7);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

endpackage

>>> design/md5_ctrl.sv
// md5 engine controller: sequences absorb, padding, rounds and digest emission
// depends on md5_pkg
module md5_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  md5_pkg::in_item_t   in_data,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          emit_index,
  output md5_pkg::md5_cmd_t   cmd,
  input  md5_pkg::md5_status_t stat
);

  md5_pkg::md5_state_t state, state_next;
  logic finishing, finishing_next;
  logic [1:0] emit_index_next;
  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= md5_pkg::ST_IDLE;
      finishing  <= 1'b0;
      emit_index <= '0;
    end else begin
      state      <= state_next;
      finishing  <= finishing_next;
      emit_index <= emit_index_next;
    end
  end

  always_comb begin
    state_next      = state;
    finishing_next  = finishing;
    emit_index_next = emit_index;
    case (state)
      md5_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == md5_pkg::CMD_FINISH) begin
            finishing_next = 1'b1;
            state_next = (stat.pos == 6'd63) ? md5_pkg::ST_ROUND : md5_pkg::ST_PAD;
          end else if (stat.pos == 6'd63) begin
            state_next = md5_pkg::ST_ROUND;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (stat.pos == 6'd63) state_next = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        if (stat.round == 6'd63) state_next = md5_pkg::ST_FOLD;
      end
      md5_pkg::ST_FOLD: begin
        if (!finishing) state_next = md5_pkg::ST_IDLE;
        else if (stat.in_tail) state_next = md5_pkg::ST_EMIT;
        else state_next = md5_pkg::ST_PAD;
      end
      md5_pkg::ST_EMIT: begin
        if (!out_stall) begin
          emit_index_next = emit_index + 2'd1;
          if (emit_index == 2'd3) begin
            state_next = md5_pkg::ST_IDLE;
            finishing_next = 1'b0;
          end
        end
      end
      default: state_next = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.src   = md5_pkg::SRC_DATA;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      md5_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          cmd.wr_byte = 1'b1;
          if (in_data.command == md5_pkg::CMD_FINISH) begin
            cmd.src = md5_pkg::SRC_PAD;
            cmd.save_len = 1'b1;
          end else begin
            cmd.count_up = 1'b1;
          end
          cmd.start_rounds = (stat.pos == 6'd63);
        end
      end
      md5_pkg::ST_PAD: begin
        cmd.wr_byte = 1'b1;
        // length bytes only in the block that carries the tail
        cmd.src = (stat.in_tail && stat.pos >= md5_pkg::LEN_POS) ?
                  md5_pkg::SRC_LEN : md5_pkg::SRC_ZERO;
        cmd.start_rounds = (stat.pos == 6'd63);
      end
      md5_pkg::ST_ROUND: cmd.round_step = 1'b1;
      md5_pkg::ST_FOLD:  cmd.fold = 1'b1;
      md5_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.reinit = !out_stall && (emit_index == 2'd3);
      end
      default: ;
    endcase
  end

  // a byte write never coincides with a round
  assert property (@(posedge clk) disable iff (rst) !(cmd.wr_byte && cmd.round_step))
    else $error("byte write during compression");
  // emission only happens while finishing
  assert property (@(posedge clk) disable iff (rst) out_valid |-> finishing)
    else $error("digest emitted outside finish");
  // a stalled digest word keeps its index
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |=> $stable(emit_index))
    else $error("digest index moved under stall");

endmodule

>>> design/md5_datapath.sv
// md5 engine datapath: block buffer, bit count, round unit and chaining words
// depends on md5_pkg
module md5_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  md5_pkg::in_item_t    in_data,
  input  md5_pkg::md5_cmd_t    cmd,
  input  logic [1:0]           emit_index,
  output md5_pkg::md5_status_t stat,
  output md5_pkg::out_item_t   out_data
);

  // block held as 16 little-endian message words, written one byte lane at a time
  logic [31:0] buffer [16];
  logic [63:0] bit_count;
  logic [63:0] saved_len;
  logic [5:0]  pos;
  logic [5:0]  round;
  logic        in_tail;
  logic [31:0] h [4];
  logic [31:0] wa, wb, wc, wd;
  logic [7:0]  wr_val;
  logic [31:0] m_word, f_val, sum, rot;
  logic [4:0]  s;
  logic [2:0]  len_sel;

  assign len_sel = pos[2:0];

  always_comb begin
    case (cmd.src)
      md5_pkg::SRC_DATA: wr_val = in_data.data_byte;
      md5_pkg::SRC_PAD:  wr_val = md5_pkg::PAD_BYTE;
      md5_pkg::SRC_LEN:  wr_val = saved_len[{len_sel, 3'b000} +: 8];
      default:           wr_val = 8'h00;
    endcase
  end

  // round function
  always_comb begin
    s = md5_pkg::rot_amount(round);
    case (round[5:4])
      2'd0: f_val = (wb & wc) | (~wb & wd);
      2'd1: f_val = (wb & wd) | (wc & ~wd);
      2'd2: f_val = wb ^ wc ^ wd;
      default: f_val = wc ^ (wb | ~wd);
    endcase
    sum = f_val + wa + md5_pkg::round_const(round) + m_word;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) buffer[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_val;
    if (cmd.save_len) saved_len <= bit_count;
    // message word registered in the cycle before the round that uses it
    if (cmd.start_rounds) m_word <= buffer[md5_pkg::msg_index(6'd0)];
    else if (cmd.round_step) m_word <= buffer[md5_pkg::msg_index(round + 6'd1)];
    if (cmd.start_rounds) begin
      wa <= h[0]; wb <= h[1]; wc <= h[2]; wd <= h[3];
    end else if (cmd.round_step) begin
      wa <= wd; wd <= wc; wc <= wb; wb <= wb + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reinit) begin
      bit_count <= '0;
      pos <= '0;
      round <= '0;
      in_tail <= 1'b0;
      h[0] <= md5_pkg::IV0; h[1] <= md5_pkg::IV1;
      h[2] <= md5_pkg::IV2; h[3] <= md5_pkg::IV3;
    end else begin
      if (cmd.wr_byte) begin
        pos <= pos + 6'd1;
        if (cmd.src == md5_pkg::SRC_PAD) in_tail <= (pos < md5_pkg::LEN_POS);
      end
      if (cmd.count_up) bit_count <= bit_count + 64'd8;
      if (cmd.round_step) round <= round + 6'd1;
      if (cmd.fold) begin
        in_tail <= 1'b1;
        h[0] <= h[0] + wa; h[1] <= h[1] + wb;
        h[2] <= h[2] + wc; h[3] <= h[3] + wd;
      end
    end
  end

  // in_tail marks that the length lands in the block now being compressed
  assign stat.pos = pos;
  assign stat.round = round;
  assign stat.in_tail = in_tail;

  assign out_data.digest_word = h[emit_index];
  assign out_data.word_index  = emit_index;
  assign out_data.last_word   = (emit_index == 2'd3);

endmodule

>>> design/md5_hash_engine_core.sv
// md5 hash engine top level: controller and datapath
// depends on md5_pkg, md5_ctrl, md5_datapath
// absorb: a byte that fills a block starts a compression of 64 rounds and a fold
// finish: pad bytes one per cycle, one or two compressions, then 4 digest words
// input: stalled outside idle, so a new byte waits while the single shared round unit compresses a block
// reset: synchronous, restores the initial chaining words and clears the bit count
module md5_hash_engine_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::out_item_t out_data
);

  md5_pkg::md5_cmd_t    cmd;
  md5_pkg::md5_status_t stat;
  logic [1:0]           emit_index;

  // sequencing of every transaction
  md5_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_data, .in_stall, .out_valid, .out_stall,
    .emit_index, .cmd, .stat
  );

  // storage and round arithmetic
  md5_datapath u_dp (
    .clk, .rst, .in_data, .cmd, .emit_index, .stat, .out_data
  );

endmodule

>>> verif/tb_md5_hash_engine_core.sv
// testbench for md5_hash_engine_core: random byte streams with finishes, checked
// against an in-bench md5 predictor through a small scoreboard class
// depends on md5_pkg and md5_hash_engine_core
`timescale 1ns / 100ps

module tb_md5_hash_engine_core;

  localparam int WATCHDOG_LIMIT = 20000;

  // md5 predictor: chaining words, block bytes, bit count
  class md5_digest_board;
    logic [31:0] chain [4];
    logic [7:0]  block [64];
    logic [63:0] nbits;
    md5_pkg::out_item_t pending [$];
    int          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = md5_pkg::IV0; chain[1] = md5_pkg::IV1;
      chain[2] = md5_pkg::IV2; chain[3] = md5_pkg::IV3;
      nbits = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int s);
      return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
    endfunction

    function void compress();
      logic [31:0] m [16];
      logic [31:0] w [4];
      logic [31:0] f;
      int g, ph;
      logic [31:0] kc [64];
      int sh [16];
      kc = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
      };
      sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
        m[i] = {block[4*i+3], block[4*i+2], block[4*i+1], block[4*i]};
      for (int i = 0; i < 4; i++) w[i] = chain[i];
      for (int k = 0; k < 64; k++) begin
        ph = k / 16;
        case (ph)
          0: begin f = (w[1] & w[2]) | (~w[1] & w[3]); g = k; end
          1: begin f = (w[1] & w[3]) | (w[2] & ~w[3]); g = (5*k + 1) % 16; end
          2: begin f = w[1] ^ w[2] ^ w[3]; g = (3*k + 5) % 16; end
          default: begin f = w[2] ^ (w[1] | ~w[3]); g = (7*k) % 16; end
        endcase
        f = f + w[0] + kc[k] + m[g];
        w[0] = w[3]; w[3] = w[2]; w[2] = w[1];
        w[1] = w[1] + rotl(f, sh[ph*4 + k%4]);
      end
      for (int i = 0; i < 4; i++) chain[i] += w[i];
    endfunction

    function void put(logic [7:0] b);
      int p;
      p = nbits[8:3];
      block[p] = b;
      nbits += 64'd8;
      if (p == 63) compress();
    endfunction

    // note one accepted input transaction
    function void note_input(md5_pkg::in_item_t it);
      logic [63:0] len;
      md5_pkg::out_item_t o;
      if (it.command == md5_pkg::CMD_ABSORB) begin
        put(it.data_byte);
        return;
      end
      len = nbits;
      put(md5_pkg::PAD_BYTE);
      while (nbits[8:3] != 6'd56) put(8'h00);
      for (int k = 0; k < 8; k++) put(len[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
        o.digest_word = chain[k];
        o.word_index  = k[1:0];
        o.last_word   = (k == 3);
        pending.push_back(o);
      end
      restart();
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("digest %s: got %h, expected %h", what, got, want);
      errors++;
    endfunction

    // check one accepted result transaction
    function void check_output(md5_pkg::out_item_t o);
      md5_pkg::out_item_t e;
      if (pending.size() == 0) begin
        report("unexpected word", o.digest_word, 32'h0);
        return;
      end
      e = pending.pop_front();
      if (o.digest_word !== e.digest_word) report("word", o.digest_word, e.digest_word);
      if (o.word_index !== e.word_index)
        report("index", 32'(o.word_index), 32'(e.word_index));
      if (o.last_word !== e.last_word)
        report("last", 32'(o.last_word), 32'(e.last_word));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  md5_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  md5_pkg::out_item_t out_data;

  md5_digest_board board = new();
  int idle_cycles = 0;
  bit sending_done = 1'b0;

  always #2 clk = ~clk;

  md5_hash_engine_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // mostly short gaps, a few long ones, some stretches with none
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input transaction: optional gap, then hold valid until accepted
  task automatic send_item(logic cmd, logic [7:0] b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, data_byte: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(in_data);
  endtask

  task automatic send_message(int nbytes);
    for (int i = 0; i < nbytes; i++) send_item(md5_pkg::CMD_ABSORB, 8'($urandom));
    send_item(md5_pkg::CMD_FINISH, 8'($urandom));
  endtask

  // result side: random stall, check on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_output(out_data);
      out_stall <= (gap_len() > 0);
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else if (!sending_done || board.pending.size() > 0) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("md5_hash_engine_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int n, r, sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, finish with data bits set, standard vector "abc"
    send_item(md5_pkg::CMD_FINISH, 8'h00);
    send_item(md5_pkg::CMD_FINISH, 8'hff);
    send_item(md5_pkg::CMD_ABSORB, 8'h61);
    send_item(md5_pkg::CMD_ABSORB, 8'h62);
    send_item(md5_pkg::CMD_ABSORB, 8'h63);
    send_item(md5_pkg::CMD_FINISH, 8'h5a);
    // byte extremes, then length 55/56 boundary for one vs two compressions
    send_item(md5_pkg::CMD_ABSORB, 8'h00);
    send_item(md5_pkg::CMD_ABSORB, 8'hff);
    send_item(md5_pkg::CMD_ABSORB, 8'h55);
    send_item(md5_pkg::CMD_ABSORB, 8'haa);
    send_item(md5_pkg::CMD_FINISH, 8'h00);

    // pause until every digest word has come back
    in_valid <= 1'b0;
    while (board.pending.size() > 0) @(posedge clk);

    sent = 0;
    send_message(55); send_message(56); send_message(63); send_message(64);
    sent = 242;
    while (sent < 480) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(0, 20) : $urandom_range(50, 130);
      // keep the total close to the intended item count
      if (n > 479 - sent) n = 479 - sent;
      send_message(n);
      sent += n + 1;
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;

    while (board.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("md5_hash_engine_core: match");
    end else begin
      $display("md5_hash_engine_core: mismatch");
    end
    $finish;
  end
endmodule
